/* src/lfu_pkg.sv */
package lfu_pkg;

   // field widths of the request, response and entry store
   localparam int CSR_W   = 5;
   localparam int KEY_W   = 32;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 32;
   localparam int STAMP_W = 48;

   // capacity register value after reset
   localparam logic [CSR_W-1:0] CAP_RESET = 5'd16;

   // request kinds carried on tuser
   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_STORE  = 1'b1;

   // data returned for anything but a lookup hit (all ones, i.e. -1)
   localparam logic [DATA_W-1:0] MISS_DATA = '1;

   // use count limits
   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_FIRST = 32'd1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_req;   // capture the accepted item, clear the scan trackers
      logic rd_en;      // read one entry at the scan address
      logic commit;     // update the table and load the response register
   } cmd_type;

   // one table entry
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [DATA_W-1:0]  value;
      logic [COUNT_W-1:0] count;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   // saturating increment of a use count
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      logic [COUNT_W-1:0] r;
      r = (c == COUNT_MAX) ? c : c + COUNT_FIRST;
      return r;
   endfunction

endpackage

/* src/lfu_ctrl.sv */
module lfu_ctrl #(
   parameter int CAPACITY = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output lfu_pkg::cmd_type      cmd,
   output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] rd_addr
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              out_free;

   assign accept   = req_tvalid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // command decode
   assign req_tready   = (state_ff == ST_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign cmd.load_req = accept;
   assign cmd.rd_en    = (state_ff == ST_SCAN);
   assign cmd.commit   = (state_ff == ST_COMMIT) && out_free;
   assign rd_addr      = scan_ff;

   // next state
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               scan_in  = '0;
            end
         end
         ST_SCAN: begin
            if (scan_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a commit never overwrites a response that is still waiting
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("commit while response register busy");

   // every commit presents a response on the next cycle
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit without response");

endmodule

/* src/lfu_dp.sv */
module lfu_dp #(
   parameter int CAPACITY = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [lfu_pkg::CSR_W-1:0]     csr_wr_data,
   input  logic                          req_tuser,
   input  logic [63:0]                   req_tdata,
   input  lfu_pkg::cmd_type              cmd,
   input  logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
   output logic                          rsp_tuser,
   output logic [lfu_pkg::DATA_W-1:0]    rsp_tdata
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int CW    = (OCC_W > lfu_pkg::CSR_W) ? OCC_W : lfu_pkg::CSR_W;

   // capacity register
   logic [lfu_pkg::CSR_W-1:0] cap_ff, cap_in;

   // captured request
   logic                        mode_ff;
   logic [lfu_pkg::KEY_W-1:0]   key_ff;
   logic [lfu_pkg::DATA_W-1:0]  din_ff;

   // entry store and scan read port
   lfu_pkg::entry_type mem [CAPACITY];
   lfu_pkg::entry_type rd_q_ff;
   logic               rd_pend_ff;
   logic [IDX_W-1:0]   rd_idx_ff;

   // scan trackers
   logic                         match_found_ff, match_found_in;
   logic [IDX_W-1:0]             match_idx_ff, match_idx_in;
   logic [lfu_pkg::DATA_W-1:0]   match_value_ff, match_value_in;
   logic [lfu_pkg::COUNT_W-1:0]  match_count_ff, match_count_in;
   logic                         free_found_ff, free_found_in;
   logic [IDX_W-1:0]             free_idx_ff, free_idx_in;
   logic                         best_found_ff, best_found_in;
   logic [IDX_W-1:0]             best_idx_ff, best_idx_in;
   logic [lfu_pkg::COUNT_W-1:0]  best_count_ff, best_count_in;
   logic [lfu_pkg::STAMP_W-1:0]  best_stamp_ff, best_stamp_in;

   // table state
   logic [CAPACITY-1:0]          valid_ff, valid_in;
   logic [OCC_W-1:0]             occ_ff, occ_in;
   logic [lfu_pkg::STAMP_W-1:0]  seq_ff, seq_in;

   // response register
   logic                         rsp_hit_ff, rsp_hit_in;
   logic [lfu_pkg::DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // table write
   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;
   lfu_pkg::entry_type  wr_entry;
   logic [IDX_W-1:0]    slot;

   logic [CW-1:0] cap_wide, cap_eff;
   logic          cap_zero, room;
   logic          rd_valid, is_match, is_free, is_better;

   // effective capacity
   assign cap_wide = CW'(cap_ff);
   assign cap_eff  = (cap_wide > CW'(CAPACITY)) ? CW'(CAPACITY) : cap_wide;
   assign cap_zero = (cap_eff == '0);
   assign room     = (CW'(occ_ff) < cap_eff);

   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   // compare of the entry read on the previous cycle
   assign rd_valid  = valid_ff[rd_idx_ff];
   assign is_match  = rd_pend_ff && rd_valid && (rd_q_ff.key == key_ff);
   assign is_free   = rd_pend_ff && !rd_valid;
   assign is_better = rd_pend_ff && rd_valid &&
                      (!best_found_ff || (rd_q_ff.count < best_count_ff) ||
                       ((rd_q_ff.count == best_count_ff) &&
                        (rd_q_ff.stamp < best_stamp_ff)));

   // tracker update
   always_comb begin
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_value_in = match_value_ff;
      match_count_in = match_count_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      best_found_in  = best_found_ff;
      best_idx_in    = best_idx_ff;
      best_count_in  = best_count_ff;
      best_stamp_in  = best_stamp_ff;
      if (cmd.load_req) begin
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         best_found_in  = 1'b0;
      end else begin
         if (is_match && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = rd_idx_ff;
            match_value_in = rd_q_ff.value;
            match_count_in = rd_q_ff.count;
         end
         if (is_free && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
         if (is_better) begin
            best_found_in = 1'b1;
            best_idx_in   = rd_idx_ff;
            best_count_in = rd_q_ff.count;
            best_stamp_in = rd_q_ff.stamp;
         end
      end
   end

   // commit: table update and response
   assign slot = room ? free_idx_ff : best_idx_ff;

   always_comb begin
      wr_en       = 1'b0;
      wr_idx      = match_idx_ff;
      wr_entry    = '{key: key_ff, value: din_ff, count: lfu_pkg::COUNT_FIRST,
                      stamp: seq_ff};
      valid_in    = valid_ff;
      occ_in      = occ_ff;
      seq_in      = seq_ff;
      rsp_hit_in  = rsp_hit_ff;
      rsp_data_in = rsp_data_ff;
      if (cmd.commit) begin
         rsp_hit_in  = 1'b0;
         rsp_data_in = lfu_pkg::MISS_DATA;
         if (!cap_zero) begin
            if (match_found_ff) begin
               // hit: refresh count and stamp, new value on store
               rsp_hit_in     = 1'b1;
               wr_en          = 1'b1;
               wr_idx         = match_idx_ff;
               wr_entry.count = lfu_pkg::sat_inc(match_count_ff);
               seq_in         = seq_ff + 1'b1;
               if (mode_ff == lfu_pkg::MODE_LOOKUP) begin
                  rsp_data_in    = match_value_ff;
                  wr_entry.value = match_value_ff;
               end
            end else if (mode_ff == lfu_pkg::MODE_STORE) begin
               // store miss: free slot while below capacity, else the victim
               wr_en          = 1'b1;
               wr_idx         = slot;
               seq_in         = seq_ff + 1'b1;
               valid_in[slot] = 1'b1;
               if (room) begin
                  occ_in = occ_ff + 1'b1;
               end
            end
         end
      end
   end

   // request capture and scan read
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= req_tuser;
         key_ff  <= req_tdata[31:0];
         din_ff  <= req_tdata[63:32];
      end
      if (cmd.rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
      rd_idx_ff <= rd_addr;
   end

   // entry store write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
   end

   // trackers and response payload
   always_ff @(posedge clock) begin
      match_idx_ff   <= match_idx_in;
      match_value_ff <= match_value_in;
      match_count_ff <= match_count_in;
      free_idx_ff    <= free_idx_in;
      best_idx_ff    <= best_idx_in;
      best_count_ff  <= best_count_in;
      best_stamp_ff  <= best_stamp_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff         <= lfu_pkg::CAP_RESET;
         rd_pend_ff     <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         best_found_ff  <= 1'b0;
         valid_ff       <= '0;
         occ_ff         <= '0;
         seq_ff         <= '0;
      end else begin
         cap_ff         <= cap_in;
         rd_pend_ff     <= cmd.rd_en;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         best_found_ff  <= best_found_in;
         valid_ff       <= valid_in;
         occ_ff         <= occ_in;
         seq_ff         <= seq_in;
      end
   end

   assign rsp_tuser = rsp_hit_ff;
   assign rsp_tdata = rsp_data_ff;

   // occupancy tracks the number of valid entries
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      int'(occ_ff) == $countones(valid_ff))
      else $error("occupancy out of step with valid bits");

   // a store miss below capacity always found a free slot
   a_free_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !cap_zero && !match_found_ff &&
       (mode_ff == lfu_pkg::MODE_STORE) && room) |-> free_found_ff)
      else $error("store miss below capacity without free slot");

   // a store miss at capacity always found a victim
   a_victim: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !cap_zero && !match_found_ff &&
       (mode_ff == lfu_pkg::MODE_STORE) && !room) |-> best_found_ff)
      else $error("store miss at capacity without victim");

endmodule

/* src/lfu_cache_policy_core.sv */
// an item passes the entry scan, a drain step and the commit; the commit waits until
//   the output register is free; a new item is taken only after the previous commit
// the entry scan reads one table entry per cycle through a single read port
// a new item is taken while the previous response still waits on the output
// reset (synchronous): all entries invalid, occupancy and order counter zero,
//   capacity register 16
module lfu_cache_policy_core #(
   parameter int CAPACITY = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [lfu_pkg::CSR_W-1:0]   csr_wr_data,   // capacity
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [63:0]                 req_tdata,     // key [31:0], data_in [63:32]
   input  logic                        req_tuser,     // mode
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [lfu_pkg::DATA_W-1:0]  rsp_tdata,     // data_out [31:0]
   output logic                        rsp_tuser      // hit
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   lfu_pkg::cmd_type  cmd;
   logic [IDX_W-1:0]  rd_addr;

   // sequencer
   lfu_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   // entry table, scan trackers and response register
   lfu_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

/* bench/tb_lfu_cache_policy_core.sv */
`timescale 1ns / 1ps

module tb_lfu_cache_policy_core;

   localparam int ENTRIES     = 16;
   localparam int POOL_SIZE   = 24;
   localparam int CYCLE_LIMIT = 200000;

   // one answer of the cache: hit flag and returned value
   typedef struct packed {
      logic                       hit;
      logic [lfu_pkg::DATA_W-1:0] data;
   } answer_type;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         csr_wr_en   = 1'b0;
   logic [lfu_pkg::CSR_W-1:0]    csr_wr_data = '0;
   logic                         req_tvalid  = 1'b0;
   logic                         req_tready;
   logic [63:0]                  req_tdata   = '0;   // key [31:0], data_in [63:32]
   logic                         req_tuser   = 1'b0; // mode
   logic                         rsp_tvalid;
   logic                         rsp_tready  = 1'b0;
   logic [lfu_pkg::DATA_W-1:0]   rsp_tdata;          // data_out [31:0]
   logic                         rsp_tuser;          // hit

   // shadow copy of the table and its capacity register
   logic [lfu_pkg::CSR_W-1:0]    shadow_cap;
   logic                         slot_valid [ENTRIES];
   logic [lfu_pkg::KEY_W-1:0]    slot_key   [ENTRIES];
   logic [lfu_pkg::DATA_W-1:0]   slot_value [ENTRIES];
   logic [lfu_pkg::COUNT_W-1:0]  slot_count [ENTRIES];
   logic [lfu_pkg::STAMP_W-1:0]  slot_stamp [ENTRIES];
   int unsigned                  shadow_occupancy;
   logic [lfu_pkg::STAMP_W-1:0]  shadow_sequence;

   answer_type                   answer_q[$];
   logic [lfu_pkg::KEY_W-1:0]    key_pool [POOL_SIZE];
   bit                           idle_on        = 1'b1;
   int                           stall_left     = 0;
   int                           mismatch_count = 0;
   int unsigned                  cycle_count    = 0;

   lfu_cache_policy_core #(
      .CAPACITY (ENTRIES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // clock
   always #2 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each response with the oldest predicted answer
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answer_q.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual hit %0b data %h",
                     $time, rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            want = answer_q.pop_front();
            if (rsp_tuser !== want.hit) begin
               $display("%0t: hit mismatch, expected %0b actual %0b",
                        $time, want.hit, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata !== want.data) begin
               $display("%0t: data mismatch, expected %h actual %h",
                        $time, want.data, rsp_tdata);
               mismatch_count++;
            end
         end
      end
   end

   // count up with saturation and take a fresh order stamp
   function automatic void raise_count(input int idx);
      if (slot_count[idx] != lfu_pkg::COUNT_MAX)
         slot_count[idx] = slot_count[idx] + 1'b1;
      slot_stamp[idx] = shadow_sequence;
      shadow_sequence = shadow_sequence + 1'b1;
   endfunction

   // answer of one lookup or store, updating the shadow table
   function automatic answer_type cache_access(
      input logic                       mode,
      input logic [lfu_pkg::KEY_W-1:0]  k,
      input logic [lfu_pkg::DATA_W-1:0] v
   );
      answer_type  ans;
      int unsigned cap;
      int          found;
      int          slot;
      ans.hit  = 1'b0;
      ans.data = lfu_pkg::MISS_DATA;
      cap = (shadow_cap > ENTRIES) ? ENTRIES : shadow_cap;
      if (cap == 0)
         return ans;
      found = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (found < 0 && slot_valid[i] && slot_key[i] == k)
            found = i;
      if (found >= 0) begin
         ans.hit = 1'b1;
         if (mode == lfu_pkg::MODE_LOOKUP)
            ans.data = slot_value[found];
         else
            slot_value[found] = v;
         raise_count(found);
         return ans;
      end
      if (mode == lfu_pkg::MODE_LOOKUP)
         return ans;
      // store miss: a free slot below capacity, else the least used and oldest goes
      slot = -1;
      if (shadow_occupancy < cap)
         for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !slot_valid[i])
               slot = i;
      if (slot < 0) begin
         for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && (slot < 0 || slot_count[i] < slot_count[slot] ||
                (slot_count[i] == slot_count[slot] && slot_stamp[i] < slot_stamp[slot])))
               slot = i;
         if (slot >= 0) begin
            slot_valid[slot] = 1'b0;
            if (shadow_occupancy > 0)
               shadow_occupancy--;
         end
      end
      if (slot >= 0) begin
         slot_valid[slot] = 1'b1;
         slot_key[slot]   = k;
         slot_value[slot] = v;
         slot_count[slot] = lfu_pkg::COUNT_FIRST;
         slot_stamp[slot] = shadow_sequence;
         shadow_sequence  = shadow_sequence + 1'b1;
         shadow_occupancy++;
      end
      return ans;
   endfunction

   // offer one item, wait for its acceptance, record the predicted answer
   task automatic send_item(input logic mode, input logic [lfu_pkg::KEY_W-1:0] k,
                            input logic [lfu_pkg::DATA_W-1:0] v);
      answer_type ans;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, $urandom};
         req_tuser  <= 1'($urandom_range(0, 1));
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {v, k};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      ans = cache_access(mode, k, v);
      answer_q = {answer_q, ans};
   endtask

   // stop offering and wait until every answer is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (answer_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // capacity write while the block is idle
   task automatic set_capacity(input logic [lfu_pkg::CSR_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_cap = value;
   endtask

   // empty table after reset, extreme keys and values, store hit overwrite
   task automatic test_empty_and_extremes();
      send_item(lfu_pkg::MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send_item(lfu_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h1234_5678);
      send_item(lfu_pkg::MODE_STORE,  32'h0000_0000, 32'h8000_0000);
      send_item(lfu_pkg::MODE_STORE,  32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_item(lfu_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(lfu_pkg::MODE_STORE,  32'h0000_0000, 32'hFFFF_FFFF);
      send_item(lfu_pkg::MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
   endtask

   // equal counts: the entry that reached its count first is evicted
   task automatic test_count_tie_break();
      set_capacity(5'd2);
      send_item(lfu_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(lfu_pkg::MODE_STORE,  32'h0000_0005, 32'h0000_0055);
      send_item(lfu_pkg::MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send_item(lfu_pkg::MODE_LOOKUP, 32'h0000_0005, 32'h0000_0000);
   endtask

   // zero capacity hides held entries, they come back afterwards
   task automatic test_capacity_zero();
      set_capacity(5'd0);
      send_item(lfu_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(lfu_pkg::MODE_STORE,  32'h0000_0009, 32'h0000_0099);
      set_capacity(5'd16);
      send_item(lfu_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(lfu_pkg::MODE_LOOKUP, 32'h0000_0009, 32'h0000_0000);
   endtask

   // capacity below occupancy evicts one per store miss; above the table size clamps
   task automatic test_capacity_shrink_and_above();
      send_item(lfu_pkg::MODE_STORE,  32'hA5A5_5A5A, 32'h0F0F_0F0F);
      send_item(lfu_pkg::MODE_STORE,  32'h5A5A_A5A5, 32'hF0F0_F0F0);
      set_capacity(5'd1);
      send_item(lfu_pkg::MODE_STORE,  32'h0000_0100, 32'h0000_0001);
      send_item(lfu_pkg::MODE_LOOKUP, 32'h0000_0100, 32'h0000_0000);
      send_item(lfu_pkg::MODE_LOOKUP, 32'hA5A5_5A5A, 32'h0000_0000);
      set_capacity(5'd31);
      send_item(lfu_pkg::MODE_STORE,  32'hFFFF_0000, 32'h0000_FFFF);
      send_item(lfu_pkg::MODE_LOOKUP, 32'hFFFF_0000, 32'h0000_0000);
   endtask

   // one phase of random traffic over the first span keys of the pool
   task automatic run_random_phase(input logic [lfu_pkg::CSR_W-1:0] cap, input int span,
                                   input int count);
      logic [lfu_pkg::KEY_W-1:0] k;
      set_capacity(cap);
      repeat (count) begin
         if ($urandom_range(0, 9) < 8)
            k = key_pool[$urandom_range(0, span - 1)];
         else
            k = $urandom;
         send_item(1'($urandom_range(0, 1)), k, $urandom);
      end
   endtask

   // random traffic across several capacities, the last phase without idling
   task automatic test_random_traffic();
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;
      key_pool[0] = '0;
      key_pool[1] = '1;
      run_random_phase(5'd16, POOL_SIZE, 50);
      run_random_phase(5'd1, 3, 50);
      run_random_phase(5'd3, 6, 50);
      run_random_phase(5'd31, POOL_SIZE, 50);
      run_random_phase(5'd8, 12, 50);
      run_random_phase(5'd0, 8, 25);
      run_random_phase(5'd2, 4, 50);
      run_random_phase(lfu_pkg::CSR_W'($urandom_range(0, 31)), 16, 50);
      idle_on = 1'b0;
      run_random_phase(5'd16, POOL_SIZE, 75);
   endtask

   // test sequence
   initial begin
      shadow_cap       = lfu_pkg::CAP_RESET;
      shadow_occupancy = 0;
      shadow_sequence  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_valid[i] = 1'b0;
         slot_key[i]   = '0;
         slot_value[i] = '0;
         slot_count[i] = '0;
         slot_stamp[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_extremes();
      test_count_tie_break();
      test_capacity_zero();
      test_capacity_shrink_and_above();
      test_random_traffic();

      wait_drained();
      repeat (3 * ENTRIES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
